// ===== rtl/core/iat_pkg.sv =====
// Package for the indexed array table: field widths, command and status codes,
// datapath operation codes and the control/flag structures shared by the modules.
// Depends on nothing; compile it first.
package iat_pkg;

   // Default sizes handed to the top level.
   localparam int CAPACITY_DEFAULT  = 64;
   localparam int WORD_BITS_DEFAULT = 32;

   // Fixed widths of the transaction fields.
   localparam int CMD_BITS    = 3;
   localparam int POS_BITS    = 8;
   localparam int RUN_BITS    = 8;
   localparam int DATA_BITS   = 32;
   localparam int LENGTH_BITS = 7;
   localparam int STATUS_BITS = 2;

   // Command codes.
   localparam logic [CMD_BITS-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_POP    = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_INSERT = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_SET    = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_DELETE = 3'd4;
   localparam logic [CMD_BITS-1:0] CMD_GET    = 3'd5;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 3'd6;

   // Status codes.
   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

   // One datapath operation per cycle, chosen by the controller.
   typedef enum logic [4:0] {
      DP_NOP,
      DP_SET_FULL,
      DP_SET_EMPTY,
      DP_CAPTURE,
      DP_PUSH_WR,
      DP_POP_RD,
      DP_GET_RD,
      DP_SET_WR,
      DP_FILL_START,
      DP_FILL_ZERO,
      DP_FILL_LAST,
      DP_INS_START,
      DP_UP_RD,
      DP_UP_WR,
      DP_INS_LAST,
      DP_DEL_TRUNC,
      DP_DEL_START,
      DP_DN_RD,
      DP_DN_WR,
      DP_DEL_LAST,
      DP_CLEAR
   } dp_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic      load_req;
      dp_op_type op;
   } ctl_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic [CMD_BITS-1:0] command;
      logic                pos_lt_count;
      logic                pos_ge_cap;
      logic                is_full;
      logic                is_empty;
      logic                run_zero;
      logic                end_ge_count;
      logic                fill_more;
      logic                up_more;
      logic                dn_more;
   } dp_flags_type;

endpackage

// ===== rtl/core/iat_if.sv =====
// Channel interfaces of the indexed array table: request and response, each with
// valid/ready handshake and payload. Depends on iat_pkg for the field widths.
interface iat_req_if;
   logic                             valid;
   logic                             ready;
   logic [iat_pkg::CMD_BITS-1:0]     command;
   logic [iat_pkg::POS_BITS-1:0]     position;
   logic [iat_pkg::RUN_BITS-1:0]     run_count;
   logic [iat_pkg::DATA_BITS-1:0]    write_word;

   modport source (output valid, command, position, run_count, write_word, input ready);
   modport sink   (input valid, command, position, run_count, write_word, output ready);
endinterface

interface iat_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [iat_pkg::DATA_BITS-1:0]    read_word;
   logic [iat_pkg::LENGTH_BITS-1:0]  fill_length;
   logic [iat_pkg::STATUS_BITS-1:0]  status;

   modport source (output valid, read_word, fill_length, status, input ready);
   modport sink   (input valid, read_word, fill_length, status, output ready);
endinterface

// ===== rtl/core/indexed_array_table_top.sv =====
// Top level of the indexed array table: joins the controller and the datapath to
// the request and response channels. Depends on iat_pkg, iat_if, iat_ctrl, iat_dpath.
//
//   channel    direction   handshake    payload
//   req_chan   in          valid/ready  command, position, run_count, write_word
//   rsp_chan   out         valid/ready  read_word, fill_length, status
//
// Push, set, clear, truncating delete and the no-change cases finish in the execute
// state; pop and get add a wait for the registered memory read. Set or insert at or
// past the end zeroes the gap entries one at a time before writing the word, and
// insert or delete inside the array moves each entry with a read and then a write,
// as the entry memory has a single read and a single write port.
// A new transaction is accepted in the cycle the previous response is taken.
// Reset is synchronous and empties the array; entry contents are left as they are.
module indexed_array_table_top #(
   parameter int CAPACITY  = iat_pkg::CAPACITY_DEFAULT,
   parameter int WORD_BITS = iat_pkg::WORD_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   iat_req_if.sink    req_chan,
   iat_rsp_if.source  rsp_chan
);

   iat_pkg::ctl_cmd_type  ctl;
   iat_pkg::dp_flags_type flags;

   // Command sequencer.
   iat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .flags     (flags),
      .ctl       (ctl)
   );

   // Entry storage and arithmetic.
   iat_dpath #(
      .CAPACITY  (CAPACITY),
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .command     (req_chan.command),
      .position    (req_chan.position),
      .run_count   (req_chan.run_count),
      .write_word  (req_chan.write_word),
      .flags       (flags),
      .read_word   (rsp_chan.read_word),
      .fill_length (rsp_chan.fill_length),
      .status      (rsp_chan.status)
   );

`ifndef SYNTHESIS
   // A waiting response holds off new requests.
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("Request accepted while a response was still waiting.");

   // No response is shown in the cycle after a request is accepted.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !rsp_chan.valid)
      else $error("Response raised in the cycle after acceptance.");

   // An empty status only ever reports an empty array.
   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == iat_pkg::ST_EMPTY)) |->
         (rsp_chan.fill_length == '0))
      else $error("Empty status with a non-zero fill length.");
`endif

endmodule

// ===== rtl/core/iat_dpath.sv =====
// Datapath of the indexed array table: entry memory, fill length, move pointer,
// latched request and response registers. Depends on iat_pkg; driven by iat_ctrl.
module iat_dpath #(
   parameter int CAPACITY  = iat_pkg::CAPACITY_DEFAULT,
   parameter int WORD_BITS = iat_pkg::WORD_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  iat_pkg::ctl_cmd_type               ctl,
   input  logic [iat_pkg::CMD_BITS-1:0]       command,
   input  logic [iat_pkg::POS_BITS-1:0]       position,
   input  logic [iat_pkg::RUN_BITS-1:0]       run_count,
   input  logic [iat_pkg::DATA_BITS-1:0]      write_word,
   output iat_pkg::dp_flags_type              flags,
   output logic [iat_pkg::DATA_BITS-1:0]      read_word,
   output logic [iat_pkg::LENGTH_BITS-1:0]    fill_length,
   output logic [iat_pkg::STATUS_BITS-1:0]    status
);

   localparam int AW       = $clog2(CAPACITY);
   localparam int LEN_BITS = $clog2(CAPACITY + 1);
   localparam int CW       = (LEN_BITS > iat_pkg::POS_BITS + 1) ? LEN_BITS
                                                                  : iat_pkg::POS_BITS + 1;
   localparam int DB       = iat_pkg::DATA_BITS;
   localparam int LB       = iat_pkg::LENGTH_BITS;

   // Latched request.
   logic [iat_pkg::CMD_BITS-1:0]    cmd_ff;
   logic [iat_pkg::POS_BITS-1:0]    pos_ff;
   logic [iat_pkg::RUN_BITS-1:0]    run_ff;
   logic [WORD_BITS-1:0]            word_ff;

   // Array state and working registers.
   logic [LEN_BITS-1:0]             count_ff, count_in;
   logic [LEN_BITS-1:0]             ptr_ff, ptr_in;
   logic [DB-1:0]                   rd_word_ff, rd_word_in;
   logic [iat_pkg::STATUS_BITS-1:0] status_ff, status_in;

   // Entry memory with one write port and one registered read port.
   logic [WORD_BITS-1:0]            entries_ff [CAPACITY];
   logic [WORD_BITS-1:0]            rdata_ff;
   logic                            mem_we;
   logic [AW-1:0]                   mem_waddr;
   logic [AW-1:0]                   mem_raddr;
   logic [WORD_BITS-1:0]            mem_wdata;

   // Widened views for compares and index arithmetic.
   logic [CW-1:0] pos_w, run_w, count_w, ptr_w, end_w, cap_w;

   assign pos_w   = CW'(pos_ff);
   assign run_w   = CW'(run_ff);
   assign count_w = CW'(count_ff);
   assign ptr_w   = CW'(ptr_ff);
   assign end_w   = pos_w + run_w;
   assign cap_w   = CW'(CAPACITY);

   // Status flags for the controller.
   always_comb begin
      flags.command      = cmd_ff;
      flags.pos_lt_count = (pos_w < count_w);
      flags.pos_ge_cap   = (pos_w >= cap_w);
      flags.is_full      = (count_w == cap_w);
      flags.is_empty     = (count_ff == '0);
      flags.run_zero     = (run_ff == '0);
      flags.end_ge_count = (end_w >= count_w);
      flags.fill_more    = (ptr_w < pos_w);
      flags.up_more      = (ptr_w > pos_w);
      flags.dn_more      = (ptr_w < count_w);
   end

   // Operation decode: memory port controls and next register values.
   always_comb begin
      mem_we     = 1'b0;
      mem_waddr  = AW'(ptr_ff);
      mem_raddr  = AW'(ptr_ff);
      mem_wdata  = word_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      rd_word_in = rd_word_ff;
      status_in  = status_ff;
      unique case (ctl.op)
         iat_pkg::DP_SET_FULL:  status_in = iat_pkg::ST_FULL;
         iat_pkg::DP_SET_EMPTY: status_in = iat_pkg::ST_EMPTY;
         iat_pkg::DP_CAPTURE:   rd_word_in = DB'(rdata_ff);
         iat_pkg::DP_PUSH_WR: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(count_ff);
            count_in  = count_ff + LEN_BITS'(1);
         end
         iat_pkg::DP_POP_RD: begin
            mem_raddr = AW'(count_ff - LEN_BITS'(1));
            count_in  = count_ff - LEN_BITS'(1);
         end
         iat_pkg::DP_GET_RD: mem_raddr = AW'(pos_ff);
         iat_pkg::DP_SET_WR: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(pos_ff);
         end
         iat_pkg::DP_FILL_START: ptr_in = count_ff;
         iat_pkg::DP_FILL_ZERO: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(ptr_ff);
            mem_wdata = '0;
            ptr_in    = ptr_ff + LEN_BITS'(1);
         end
         iat_pkg::DP_FILL_LAST: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(pos_ff);
            count_in  = LEN_BITS'(pos_w + CW'(1));
         end
         iat_pkg::DP_INS_START: ptr_in = count_ff;
         iat_pkg::DP_UP_RD: mem_raddr = AW'(ptr_ff - LEN_BITS'(1));
         iat_pkg::DP_UP_WR: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(ptr_ff);
            mem_wdata = rdata_ff;
            ptr_in    = ptr_ff - LEN_BITS'(1);
         end
         iat_pkg::DP_INS_LAST: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(pos_ff);
            count_in  = count_ff + LEN_BITS'(1);
         end
         iat_pkg::DP_DEL_TRUNC: count_in = LEN_BITS'(pos_w);
         iat_pkg::DP_DEL_START: ptr_in = LEN_BITS'(end_w);
         iat_pkg::DP_DN_RD: mem_raddr = AW'(ptr_ff);
         iat_pkg::DP_DN_WR: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(ptr_w - run_w);
            mem_wdata = rdata_ff;
            ptr_in    = ptr_ff + LEN_BITS'(1);
         end
         iat_pkg::DP_DEL_LAST: count_in = LEN_BITS'(count_w - run_w);
         iat_pkg::DP_CLEAR:    count_in = '0;
         default: ;
      endcase
      // A new transaction starts with a clean response.
      if (ctl.load_req) begin
         rd_word_in = '0;
         status_in  = iat_pkg::ST_OK;
      end
   end

   // Fill length is control state and is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         cmd_ff  <= command;
         pos_ff  <= position;
         run_ff  <= run_count;
         word_ff <= WORD_BITS'(write_word);
      end
      ptr_ff     <= ptr_in;
      rd_word_ff <= rd_word_in;
      status_ff  <= status_in;
   end

   // Entry memory.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries_ff[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= entries_ff[mem_raddr];
   end

   assign read_word   = rd_word_ff;
   assign fill_length = LB'(count_ff);
   assign status      = status_ff;

endmodule

// ===== rtl/core/iat_ctrl.sv =====
// Controller of the indexed array table: the command sequencer and the response
// valid flag. Depends on iat_pkg; steers iat_dpath through ctl_cmd_type.
module iat_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  iat_pkg::dp_flags_type flags,
   output iat_pkg::ctl_cmd_type  ctl
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_READ_WAIT,
      S_FILL,
      S_UP_CHK,
      S_UP_WAIT,
      S_DN_CHK,
      S_DN_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      done;

   // A new transaction is taken only once the response register is free.
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath command.
   always_comb begin
      state_in     = state_ff;
      ctl.load_req = 1'b0;
      ctl.op       = iat_pkg::DP_NOP;
      done         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               ctl.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (flags.command)
               iat_pkg::CMD_PUSH: begin
                  ctl.op = flags.is_full ? iat_pkg::DP_SET_FULL : iat_pkg::DP_PUSH_WR;
                  done   = 1'b1;
               end
               iat_pkg::CMD_POP: begin
                  if (flags.is_empty) begin
                     ctl.op = iat_pkg::DP_SET_EMPTY;
                     done   = 1'b1;
                  end else begin
                     ctl.op   = iat_pkg::DP_POP_RD;
                     state_in = S_READ_WAIT;
                  end
               end
               iat_pkg::CMD_INSERT: begin
                  if (!flags.pos_lt_count) begin
                     if (flags.pos_ge_cap) begin
                        ctl.op = iat_pkg::DP_SET_FULL;
                        done   = 1'b1;
                     end else begin
                        ctl.op   = iat_pkg::DP_FILL_START;
                        state_in = S_FILL;
                     end
                  end else if (flags.is_full) begin
                     ctl.op = iat_pkg::DP_SET_FULL;
                     done   = 1'b1;
                  end else begin
                     ctl.op   = iat_pkg::DP_INS_START;
                     state_in = S_UP_CHK;
                  end
               end
               iat_pkg::CMD_SET: begin
                  if (!flags.pos_lt_count) begin
                     if (flags.pos_ge_cap) begin
                        ctl.op = iat_pkg::DP_SET_FULL;
                        done   = 1'b1;
                     end else begin
                        ctl.op   = iat_pkg::DP_FILL_START;
                        state_in = S_FILL;
                     end
                  end else begin
                     ctl.op = iat_pkg::DP_SET_WR;
                     done   = 1'b1;
                  end
               end
               iat_pkg::CMD_DELETE: begin
                  if (flags.pos_lt_count && !flags.run_zero) begin
                     if (flags.end_ge_count) begin
                        ctl.op = iat_pkg::DP_DEL_TRUNC;
                        done   = 1'b1;
                     end else begin
                        ctl.op   = iat_pkg::DP_DEL_START;
                        state_in = S_DN_CHK;
                     end
                  end else begin
                     done = 1'b1;
                  end
               end
               iat_pkg::CMD_GET: begin
                  if (flags.pos_lt_count) begin
                     ctl.op   = iat_pkg::DP_GET_RD;
                     state_in = S_READ_WAIT;
                  end else begin
                     done = 1'b1;
                  end
               end
               iat_pkg::CMD_CLEAR: begin
                  ctl.op = iat_pkg::DP_CLEAR;
                  done   = 1'b1;
               end
               default: done = 1'b1;
            endcase
         end
         S_READ_WAIT: begin
            ctl.op = iat_pkg::DP_CAPTURE;
            done   = 1'b1;
         end
         // Zero the gap below the target index, then write the word there.
         S_FILL: begin
            if (flags.fill_more) begin
               ctl.op = iat_pkg::DP_FILL_ZERO;
            end else begin
               ctl.op = iat_pkg::DP_FILL_LAST;
               done   = 1'b1;
            end
         end
         // Move the tail up one entry at a time, from the top down.
         S_UP_CHK: begin
            if (flags.up_more) begin
               ctl.op   = iat_pkg::DP_UP_RD;
               state_in = S_UP_WAIT;
            end else begin
               ctl.op = iat_pkg::DP_INS_LAST;
               done   = 1'b1;
            end
         end
         S_UP_WAIT: begin
            ctl.op   = iat_pkg::DP_UP_WR;
            state_in = S_UP_CHK;
         end
         // Move the tail down over the deleted run, from the bottom up.
         S_DN_CHK: begin
            if (flags.dn_more) begin
               ctl.op   = iat_pkg::DP_DN_RD;
               state_in = S_DN_WAIT;
            end else begin
               ctl.op = iat_pkg::DP_DEL_LAST;
               done   = 1'b1;
            end
         end
         S_DN_WAIT: begin
            ctl.op   = iat_pkg::DP_DN_WR;
            state_in = S_DN_CHK;
         end
         default: state_in = S_IDLE;
      endcase
      if (done) begin
         state_in = S_IDLE;
      end
   end

   // Response valid: raised when a transaction completes, dropped when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         rsp_valid_in = 1'b1;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== dv/iat_table_checker.sv =====
// Checker for the indexed array table: mirrors the array contents and fill length,
// predicts one response per request transaction and compares it with the DUT.
// Depends on iat_pkg and the channel interfaces in iat_if.
module iat_table_checker #(
   parameter int CAPACITY  = iat_pkg::CAPACITY_DEFAULT,
   parameter int WORD_BITS = iat_pkg::WORD_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   iat_req_if   req_mon,
   iat_rsp_if   rsp_mon,
   output int   pending,
   output int   fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import iat_pkg::*;

   typedef struct packed {
      logic [DATA_BITS-1:0]   read_word;
      logic [LENGTH_BITS-1:0] fill_length;
      logic [STATUS_BITS-1:0] status;
   } table_reply_type;

   // Mirror of the array and the queue of responses still owed by the DUT.
   logic [WORD_BITS-1:0] word_store [CAPACITY];
   int unsigned          fill_count;
   table_reply_type      reply_q [$];
   table_reply_type      want;
   table_reply_type      got;
   logic                 bad;

   // Applies one command to the mirror and returns the response it should produce.
   function automatic table_reply_type apply_command(logic [CMD_BITS-1:0] cmd,
                                                     logic [POS_BITS-1:0] pos_in,
                                                     logic [RUN_BITS-1:0] run_in,
                                                     logic [DATA_BITS-1:0] word_in);
      table_reply_type      reply;
      int unsigned          pos;
      int unsigned          run;
      int unsigned          stop;
      int unsigned          k;
      logic [WORD_BITS-1:0] word;
      pos  = pos_in;
      run  = run_in;
      word = WORD_BITS'(word_in);
      reply.read_word = '0;
      reply.status    = ST_OK;
      case (cmd)
         CMD_PUSH: begin
            if (fill_count >= CAPACITY) begin
               reply.status = ST_FULL;
            end else begin
               word_store[fill_count] = word;
               fill_count++;
            end
         end
         CMD_POP: begin
            if (fill_count == 0) begin
               reply.status = ST_EMPTY;
            end else begin
               fill_count--;
               reply.read_word = DATA_BITS'(word_store[fill_count]);
            end
         end
         CMD_INSERT, CMD_SET: begin
            if (pos >= fill_count) begin
               // Writing past the end zero-fills the gap and extends the length.
               if (pos >= CAPACITY) begin
                  reply.status = ST_FULL;
               end else begin
                  for (k = fill_count; k < pos; k++) word_store[k] = '0;
                  word_store[pos] = word;
                  fill_count = pos + 1;
               end
            end else if (cmd == CMD_SET) begin
               word_store[pos] = word;
            end else if (fill_count >= CAPACITY) begin
               reply.status = ST_FULL;
            end else begin
               for (k = fill_count; k > pos; k--) word_store[k] = word_store[k-1];
               word_store[pos] = word;
               fill_count++;
            end
         end
         CMD_DELETE: begin
            if (pos < fill_count && run != 0) begin
               stop = pos + run;
               if (stop >= fill_count) begin
                  fill_count = pos;
               end else begin
                  for (k = stop; k < fill_count; k++) word_store[k-run] = word_store[k];
                  fill_count -= run;
               end
            end
         end
         CMD_GET: begin
            if (pos < fill_count) reply.read_word = DATA_BITS'(word_store[pos]);
         end
         CMD_CLEAR: begin
            fill_count = 0;
         end
         default: begin
         end
      endcase
      reply.fill_length = LENGTH_BITS'(fill_count);
      return reply;
   endfunction

   // Compare each accepted response with the oldest prediction, then predict the new
   // request. A response always lags its request, so the order here is safe.
   always @(posedge clock) begin
      if (reset) begin
         fill_count = 0;
         reply_q.delete();
         pending    <= 0;
         fail_count <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.read_word   = rsp_mon.read_word;
            got.fill_length = rsp_mon.fill_length;
            got.status      = rsp_mon.status;
            if (reply_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h/%0d/%0d",
                        $realtime, got.read_word, got.fill_length, got.status);
               fail_count <= fail_count + 1;
            end else begin
               want = reply_q.pop_front();
               bad  = 1'b0;
               if (got.read_word !== want.read_word) begin
                  $display("%0t: read_word mismatch, expected %h, actual %h",
                           $realtime, want.read_word, got.read_word);
                  bad = 1'b1;
               end
               if (got.fill_length !== want.fill_length) begin
                  $display("%0t: fill_length mismatch, expected %0d, actual %0d",
                           $realtime, want.fill_length, got.fill_length);
                  bad = 1'b1;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $realtime, want.status, got.status);
                  bad = 1'b1;
               end
               if (bad) fail_count <= fail_count + 1;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            reply_q.push_back(apply_command(req_mon.command, req_mon.position,
                                            req_mon.run_count, req_mon.write_word));
         end
         pending <= reply_q.size();
      end
   end

endmodule

// ===== dv/tb_indexed_array_table_top.sv =====
// Testbench top for the indexed array table: clock, reset, request stimulus and
// response back-pressure, with iat_table_checker doing prediction and comparison.
// Depends on iat_pkg, iat_if, indexed_array_table_top and iat_table_checker.
module tb_indexed_array_table_top;
   timeunit 1ns;
   timeprecision 1ps;
   import iat_pkg::*;

   // Command code the block does not use; it must leave the array alone.
   localparam logic [CMD_BITS-1:0] CMD_SPARE = 3'd7;
   localparam int RANDOM_ITEMS   = 2000;
   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic idle_on;
   int   pending;
   int   fail_count;
   int   quiet_cycles;

   iat_req_if req_chan ();
   iat_rsp_if rsp_chan ();

   always #5 clock = ~clock;

   indexed_array_table_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   iat_table_checker mirror (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .pending    (pending),
      .fail_count (fail_count)
   );

   // Response side stalls at random while idling is enabled.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= !(idle_on && $urandom_range(99) < 16);
      end
   end

   // Watchdog: too long without any transaction on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("indexed_array_table_top verification failed");
            $finish;
         end
      end
   end

   // Presents one request and returns at the edge where it is accepted.
   task automatic send_item(logic [CMD_BITS-1:0] cmd, logic [POS_BITS-1:0] pos,
                            logic [RUN_BITS-1:0] run, logic [DATA_BITS-1:0] word);
      if (idle_on && $urandom_range(99) < 16) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.command    <= cmd;
      req_chan.position   <= pos;
      req_chan.run_count  <= run;
      req_chan.write_word <= word;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Holds the request side off until every predicted response has arrived.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      int unsigned          pick;
      logic [CMD_BITS-1:0]  cmd;
      logic [POS_BITS-1:0]  pos;
      logic [RUN_BITS-1:0]  run;
      req_chan.valid      <= 1'b0;
      req_chan.command    <= CMD_PUSH;
      req_chan.position   <= '0;
      req_chan.run_count  <= '0;
      req_chan.write_word <= '0;
      idle_on             <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty and full corners, gap filling, shifts and truncation.
      send_item(CMD_POP,    8'd0,   8'd0,   32'h0);
      send_item(CMD_GET,    8'd0,   8'd0,   32'h0);
      send_item(CMD_DELETE, 8'd0,   8'd1,   32'h0);
      send_item(CMD_PUSH,   8'd0,   8'd0,   32'hFFFF_FFFF);
      send_item(CMD_PUSH,   8'd0,   8'd0,   32'h0000_0000);
      send_item(CMD_INSERT, 8'd1,   8'd0,   32'hA5A5_A5A5);
      send_item(CMD_SET,    8'd63,  8'd0,   32'h5A5A_5A5A);
      send_item(CMD_PUSH,   8'd0,   8'd0,   32'h1111_1111);
      send_item(CMD_INSERT, 8'd0,   8'd0,   32'h2222_2222);
      send_item(CMD_INSERT, 8'd64,  8'd0,   32'h3333_3333);
      send_item(CMD_SET,    8'd255, 8'd255, 32'h4444_4444);
      send_item(CMD_GET,    8'd63,  8'd0,   32'h0);
      send_item(CMD_GET,    8'd30,  8'd0,   32'h0);
      send_item(CMD_GET,    8'd255, 8'd0,   32'h0);
      send_item(CMD_SET,    8'd0,   8'd0,   32'hDEAD_BEEF);
      send_item(CMD_DELETE, 8'd0,   8'd1,   32'h0);
      send_item(CMD_DELETE, 8'd5,   8'd0,   32'h0);
      send_item(CMD_DELETE, 8'd40,  8'd255, 32'h0);
      send_item(CMD_DELETE, 8'd200, 8'd3,   32'h0);
      send_item(CMD_SPARE,  8'hFF,  8'hFF,  32'hFFFF_FFFF);
      send_item(CMD_POP,    8'd0,   8'd0,   32'h0);
      send_item(CMD_INSERT, 8'd0,   8'd0,   32'h1234_5678);
      send_item(CMD_CLEAR,  8'd0,   8'd0,   32'h0);
      send_item(CMD_INSERT, 8'd10,  8'd0,   32'h8765_4321);
      send_item(CMD_POP,    8'd0,   8'd0,   32'h0);
      wait_drained();

      // Random part: positions mostly near the fill length, short runs mostly,
      // with a quiet stretch in the middle where neither side idles.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         idle_on <= !(i >= 800 && i < 1200);
         if (i % 500 == 250) wait_drained();
         pick = $urandom_range(99);
         if (pick < 28)      cmd = CMD_PUSH;
         else if (pick < 38) cmd = CMD_POP;
         else if (pick < 52) cmd = CMD_INSERT;
         else if (pick < 64) cmd = CMD_SET;
         else if (pick < 75) cmd = CMD_DELETE;
         else if (pick < 94) cmd = CMD_GET;
         else if (pick < 97) cmd = CMD_CLEAR;
         else                cmd = CMD_SPARE;
         pos = ($urandom_range(9) == 0) ? POS_BITS'($urandom_range(255))
                                        : POS_BITS'($urandom_range(70));
         run = ($urandom_range(7) == 0) ? RUN_BITS'($urandom_range(255))
                                        : RUN_BITS'($urandom_range(4));
         send_item(cmd, pos, run, $urandom);
      end

      // Drain, let the block settle, then give the verdict.
      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("indexed_array_table_top verification clean");
      end else begin
         $display("indexed_array_table_top verification failed");
      end
      $finish;
   end

endmodule

// ===== indexed_array_table_top.f =====
rtl/core/iat_pkg.sv
rtl/core/iat_if.sv
rtl/core/iat_dpath.sv
rtl/core/iat_ctrl.sv
rtl/core/indexed_array_table_top.sv
dv/iat_table_checker.sv
dv/tb_indexed_array_table_top.sv
